### src/swtm_pkg.sv
// ----------------------------------------------------------------------------
// swtm_pkg: shared types and constants of the trimmed-mean core
// Register indexes, register widths and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package swtm_pkg;

  localparam int unsigned CFG_IDX_BITS  = 4;
  localparam int unsigned CFG_DATA_BITS = 7;
  localparam int unsigned WIN_BITS      = 7;
  localparam int unsigned TRIM_BITS     = 5;

  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_SIZE = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TRIM_COUNT  = 4'd1;

  localparam logic [WIN_BITS-1:0]  WINDOW_RESET = 7'd64;
  localparam logic [TRIM_BITS-1:0] TRIM_RESET   = 5'd1;

  typedef struct packed {
    logic accept;
    logic evict_rd;
    logic evict;
    logic insert;
    logic sum_load;
    logic sum_step;
    logic div_step;
  } swtm_cmd_t;

  typedef struct packed {
    logic evict_need;
    logic calc_ok;
    logic sum_last;
    logic div_last;
  } swtm_status_t;

endpackage

### src/swtm_in_if.sv
// ----------------------------------------------------------------------------
// swtm_in_if: sample channel
// Valid/ready channel carrying one sample per beat.
// ----------------------------------------------------------------------------
interface swtm_in_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

### src/swtm_out_if.sv
// ----------------------------------------------------------------------------
// swtm_out_if: result channel
// Valid/ready channel carrying one trimmed mean and its flag per beat.
// ----------------------------------------------------------------------------
interface swtm_out_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] trimmed_mean;
  logic                   mean_valid;

  modport source (output valid, output trimmed_mean, output mean_valid, input ready);
  modport sink   (input valid, input trimmed_mean, input mean_valid, output ready);
endinterface

### src/swtm_ctrl.sv
// ----------------------------------------------------------------------------
// swtm_ctrl: sequencing of one sample
// Evict, insert, middle-rank sum and division, then hold the result beat.
// ----------------------------------------------------------------------------
module swtm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  swtm_pkg::swtm_status_t sts,
  output swtm_pkg::swtm_cmd_t   cmd
);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_CHECK  = 9'b000000010,
    ST_RD     = 9'b000000100,
    ST_EVICT  = 9'b000001000,
    ST_INSERT = 9'b000010000,
    ST_SUMLD  = 9'b000100000,
    ST_SUM    = 9'b001000000,
    ST_DIV    = 9'b010000000,
    ST_DONE   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = sts.evict_need ? ST_RD : ST_INSERT;
      end
      ST_RD: begin
        cmd.evict_rd = 1'b1;
        state_nxt    = ST_EVICT;
      end
      ST_EVICT: begin
        cmd.evict = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_INSERT: begin
        cmd.insert = 1'b1;
        state_nxt  = sts.calc_ok ? ST_SUMLD : ST_DONE;
      end
      ST_SUMLD: begin
        cmd.sum_load = 1'b1;
        state_nxt    = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum_step = 1'b1;
        if (sts.sum_last) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

### src/swtm_datapath.sv
// ----------------------------------------------------------------------------
// swtm_datapath: window storage and arithmetic
// Arrival ring memory, sorted cell row, middle-rank adder and divider.
// ----------------------------------------------------------------------------
module swtm_datapath #(
  parameter int unsigned MAX_WINDOW  = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [swtm_pkg::CFG_IDX_BITS-1:0]    cfg_idx,
  input  logic [swtm_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  input  logic [SAMPLE_BITS-1:0]               in_sample,
  input  swtm_pkg::swtm_cmd_t                  cmd,
  output swtm_pkg::swtm_status_t               sts,
  output logic [SAMPLE_BITS-1:0]               res_mean,
  output logic                                 res_valid
);

  localparam int unsigned PTR_BITS  = $clog2(MAX_WINDOW);
  localparam int unsigned CNT_BITS  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SUM_BITS  = SAMPLE_BITS + CNT_BITS;
  localparam int unsigned DIVC_BITS = $clog2(SUM_BITS);

  logic [swtm_pkg::WIN_BITS-1:0]  win_r;
  logic [swtm_pkg::TRIM_BITS-1:0] trim_r;
  logic [SAMPLE_BITS-1:0]         smp_r;
  logic [SAMPLE_BITS-1:0]         ev_r;
  logic [PTR_BITS-1:0]            ptr_r;
  logic [CNT_BITS-1:0]            fill_r;
  logic [CNT_BITS-1:0]            idx_r;
  logic [SUM_BITS-1:0]            acc_r;
  logic [SUM_BITS-1:0]            quot_r;
  logic [CNT_BITS-1:0]            rem_r;
  logic [DIVC_BITS-1:0]           divc_r;
  logic                           ok_r;

  logic [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] srt_r    [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] sh_r     [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] ins_nxt  [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] rm_nxt   [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]  gt;
  logic [MAX_WINDOW-1:0]  ge;

  logic [CNT_BITS-1:0]  w_eff;
  logic [31:0]          w32;
  logic [31:0]          t32;
  logic [CNT_BITS-1:0]  divisor;
  logic [CNT_BITS:0]    slot_sum;
  logic [PTR_BITS-1:0]  slot;
  logic [SUM_BITS-1:0]  acc_add;
  logic [CNT_BITS:0]    trial;

  always_comb begin
    if (32'(win_r) > 32'(MAX_WINDOW)) w_eff = CNT_BITS'(MAX_WINDOW);
    else if (win_r == '0)             w_eff = CNT_BITS'(1);
    else                              w_eff = CNT_BITS'(win_r);
    w32      = 32'(w_eff);
    t32      = 32'(trim_r);
    divisor  = CNT_BITS'(w32 - 2 * t32);
    slot_sum = (CNT_BITS + 1)'(ptr_r) + (CNT_BITS + 1)'(fill_r);
    if (32'(slot_sum) >= 32'(MAX_WINDOW)) slot = PTR_BITS'(32'(slot_sum) - 32'(MAX_WINDOW));
    else                                  slot = PTR_BITS'(slot_sum);
    acc_add  = (32'(idx_r) >= t32) ? acc_r + SUM_BITS'(sh_r[0]) : acc_r;
    trial    = {rem_r, quot_r[SUM_BITS-1]} - {1'b0, divisor};
    sts.evict_need = 32'(fill_r) >= w32;
    sts.calc_ok    = (32'(fill_r) + 1 == w32) && (2 * t32 < w32);
    sts.sum_last   = 32'(idx_r) + 1 == w32 - t32;
    sts.div_last   = divc_r == DIVC_BITS'(SUM_BITS - 1);
  end

  for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
    assign gt[j] = (32'(j) >= 32'(fill_r)) || (srt_r[j] > smp_r);
    assign ge[j] = (32'(j) < 32'(fill_r)) && (srt_r[j] >= ev_r);
    if (j == 0) begin : g_first
      assign ins_nxt[j] = gt[j] ? smp_r : srt_r[j];
    end else begin : g_rest
      assign ins_nxt[j] = gt[j] ? (gt[j-1] ? srt_r[j-1] : smp_r) : srt_r[j];
    end
    if (j == MAX_WINDOW - 1) begin : g_last
      assign rm_nxt[j] = srt_r[j];
    end else begin : g_inner
      assign rm_nxt[j] = ge[j] ? srt_r[j+1] : srt_r[j];
    end

    always_ff @(posedge clk) begin
      if (cmd.insert) begin
        srt_r[j] <= ins_nxt[j];
      end else if (cmd.evict) begin
        srt_r[j] <= rm_nxt[j];
      end
      if (cmd.sum_load) begin
        sh_r[j] <= srt_r[j];
      end else if (cmd.sum_step) begin
        sh_r[j] <= (j == MAX_WINDOW - 1) ? sh_r[j] : sh_r[(j + 1) % MAX_WINDOW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) ring_mem[slot] <= smp_r;
    if (cmd.evict_rd) ev_r <= ring_mem[ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= swtm_pkg::WINDOW_RESET;
      trim_r <= swtm_pkg::TRIM_RESET;
      ptr_r  <= '0;
      fill_r <= '0;
      ok_r   <= 1'b0;
    end else begin
      if (cfg_we && cfg_idx == swtm_pkg::REG_WINDOW_SIZE) win_r <= cfg_wdata;
      if (cfg_we && cfg_idx == swtm_pkg::REG_TRIM_COUNT)
        trim_r <= cfg_wdata[swtm_pkg::TRIM_BITS-1:0];
      if (cmd.evict) begin
        fill_r <= fill_r - CNT_BITS'(1);
        ptr_r  <= (32'(ptr_r) == MAX_WINDOW - 1) ? '0 : ptr_r + PTR_BITS'(1);
      end else if (cmd.insert) begin
        fill_r <= fill_r + CNT_BITS'(1);
      end
      if (cmd.insert) ok_r <= sts.calc_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) smp_r <= in_sample;
    if (cmd.insert && !sts.calc_ok) quot_r <= '0;
    if (cmd.sum_load) begin
      idx_r <= '0;
      acc_r <= '0;
    end else if (cmd.sum_step) begin
      idx_r <= idx_r + CNT_BITS'(1);
      acc_r <= acc_add;
      if (sts.sum_last) begin
        quot_r <= acc_add;
        rem_r  <= '0;
        divc_r <= '0;
      end
    end else if (cmd.div_step) begin
      divc_r <= divc_r + DIVC_BITS'(1);
      if (!trial[CNT_BITS]) begin
        rem_r  <= trial[CNT_BITS-1:0];
        quot_r <= {quot_r[SUM_BITS-2:0], 1'b1};
      end else begin
        rem_r  <= {rem_r[CNT_BITS-2:0], quot_r[SUM_BITS-1]};
        quot_r <= {quot_r[SUM_BITS-2:0], 1'b0};
      end
    end
  end

  assign res_mean  = quot_r[SAMPLE_BITS-1:0];
  assign res_valid = ok_r;

endmodule

### src/sliding_window_trimmed_mean_core.sv
// ----------------------------------------------------------------------------
// sliding_window_trimmed_mean_core: trimmed mean over a sliding window
// Keeps the latest samples in arrival and sorted order; one result per sample.
//
//   channel | direction | payload
//   in_ch   | sink      | sample
//   out_ch  | source    | trimmed_mean, mean_valid
//   cfg_*   | write     | window_size (0), trim_count (1)
//
// One sample at a time: check, read and evict per evicted sample (0 or 1
// in steady state), insert, then middle-rank summing and bit-serial
// division when the result is valid.
// The bit-serial divider and the one-rank-a-cycle adder set the rate.
// Synchronous active-low reset; no clearing pass. A held result beat blocks
// the next sample until taken.
// ----------------------------------------------------------------------------
module sliding_window_trimmed_mean_core #(
  parameter int unsigned MAX_WINDOW  = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  swtm_in_if.sink                            in_ch,
  swtm_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [swtm_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [swtm_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

  swtm_pkg::swtm_cmd_t    cmd;
  swtm_pkg::swtm_status_t sts;

  swtm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  swtm_datapath #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_sample (in_ch.sample),
    .cmd       (cmd),
    .sts       (sts),
    .res_mean  (out_ch.trimmed_mean),
    .res_valid (out_ch.mean_valid)
  );

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the sliding-window trimmed-mean core
// Streams samples through the core under several window and trim settings,
// keeps its own arrival and sorted windows to predict each trimmed mean, and
// checks every result beat in order. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned LIMIT_CYCLES = 2000000;
  localparam int unsigned DRAIN_CYCLES = 400;
  localparam int unsigned CALM_FIRST   = 4000;
  localparam int unsigned CALM_LAST    = 16000;
  localparam logic [swtm_pkg::CFG_IDX_BITS-1:0] REG_SPARE = 4'd9;

  typedef struct packed {
    logic [15:0] mean;
    logic        ok;
  } mean_beat_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [swtm_pkg::CFG_IDX_BITS-1:0]  cfg_idx;
  logic [swtm_pkg::CFG_DATA_BITS-1:0] cfg_wdata;

  swtm_in_if  #(.SAMPLE_BITS(16)) in_if ();
  swtm_out_if #(.SAMPLE_BITS(16)) out_if ();

  sliding_window_trimmed_mean_core #(.MAX_WINDOW(64), .SAMPLE_BITS(16)) uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if.sink), .out_ch(out_if.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  logic [15:0] sample_q[$];
  mean_beat_t  mean_q[$];
  logic [15:0] arrival[$];
  logic [15:0] ranked[$];
  logic [15:0] corner_samples [14] = '{16'h0000, 16'hffff, 16'hffff, 16'hffff,
                                       16'h0000, 16'h0000, 16'h8000, 16'h7fff,
                                       16'h0001, 16'hfffe, 16'haaaa, 16'h5555,
                                       16'h5555, 16'h5555};
  int unsigned win_reg;
  int unsigned trim_reg;
  int unsigned errors;
  int unsigned cycles;
  logic beat_taken;

  initial begin
    clk = 1'b0;
  end
  always #5 clk = ~clk;

  function automatic logic stall_now();
    if (cycles >= CALM_FIRST && cycles < CALM_LAST) return 1'b0;
    return $urandom_range(99) < 38;
  endfunction

  function automatic mean_beat_t window_mean(logic [15:0] v);
    mean_beat_t r;
    int unsigned w;
    int unsigned pos;
    longint unsigned acc;
    r = '0;
    w = (win_reg < 1) ? 1 : ((win_reg > 64) ? 64 : win_reg);
    while (arrival.size() >= w) begin
      for (int i = 0; i < ranked.size(); i++) begin
        if (ranked[i] == arrival[0]) begin
          ranked.delete(i);
          break;
        end
      end
      void'(arrival.pop_front());
    end
    arrival.push_back(v);
    pos = 0;
    while (pos < ranked.size() && ranked[pos] <= v) pos++;
    ranked.insert(pos, v);
    if (arrival.size() == w && 2 * trim_reg < w) begin
      acc = 0;
      for (int unsigned i = trim_reg; i < w - trim_reg; i++) acc += ranked[i];
      r.mean = 16'(acc / (w - 2 * trim_reg));
      r.ok = 1'b1;
    end
    return r;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !stall_now();
      if (!in_if.valid || beat_taken) begin
        if (sample_q.size() > 0 && !stall_now()) begin
          in_if.sample <= sample_q.pop_front();
          in_if.valid <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    mean_beat_t got;
    mean_beat_t want;
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
    beat_taken <= rst_n && in_if.valid && in_if.ready;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.mean = out_if.trimmed_mean;
      got.ok = out_if.mean_valid;
      if (mean_q.size() == 0) begin
        $display("%0t unexpected beat: actual mean %0d flag %0b", $time, got.mean, got.ok);
        errors++;
      end else begin
        want = mean_q.pop_front();
        if (got.mean !== want.mean)
          begin
          $display("%0t trimmed_mean: expected %0d actual %0d", $time, want.mean, got.mean);
          errors++;
        end
        if (got.ok !== want.ok) begin
          $display("%0t mean_valid: expected %0b actual %0b", $time, want.ok, got.ok);
          errors++;
        end
      end
    end
    if (rst_n && in_if.valid && in_if.ready) mean_q.push_back(window_mean(in_if.sample));
  end

  task automatic settle();
    while (sample_q.size() > 0 || in_if.valid || mean_q.size() > 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [swtm_pkg::CFG_IDX_BITS-1:0] idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= swtm_pkg::CFG_DATA_BITS'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == swtm_pkg::REG_WINDOW_SIZE) win_reg = val & 'h7f;
    else if (idx == swtm_pkg::REG_TRIM_COUNT) trim_reg = val & 'h1f;
  endtask

  function automatic logic [15:0] random_sample();
    case ($urandom_range(3))
      0: return 16'($urandom_range(7));
      1: return 16'($urandom_range(65535, 65528));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic run_phase(int unsigned w, int unsigned t, int unsigned n);
    settle();
    write_reg(swtm_pkg::REG_WINDOW_SIZE, w);
    write_reg(swtm_pkg::REG_TRIM_COUNT, t);
    repeat (n) sample_q.push_back(random_sample());
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.sample = '0;
    out_if.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    beat_taken = 1'b0;
    cycles = 0;
    errors = 0;
    win_reg = swtm_pkg::WINDOW_RESET;
    trim_reg = swtm_pkg::TRIM_RESET;
    rst_n = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_reg(REG_SPARE, 'h7f);
    repeat (70) sample_q.push_back(random_sample());
    settle();
    write_reg(swtm_pkg::REG_WINDOW_SIZE, 3);
    write_reg(swtm_pkg::REG_TRIM_COUNT, 1);
    foreach (corner_samples[i]) sample_q.push_back(corner_samples[i]);
    run_phase(3, 0, 6);
    run_phase(3, 2, 5);
    run_phase(0, 0, 5);
    run_phase(127, 5, 90);
    run_phase(5, 2, 60);
    run_phase(20, 31, 40);
    run_phase(20, 9, 80);
    run_phase(40, 3, 90);
    run_phase(10, 3, 80);
    run_phase(64, 31, 110);
    run_phase(64, 0, 80);
    run_phase(33, 16, 80);
    run_phase(33, 40, 20);
    run_phase(8, 3, 120);
    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && mean_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
